// ----- rtl/bpl_pkg.sv -----
package bpl_pkg;

  localparam int DEPTH    = 256;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 32;
  localparam int BYTES_W  = 16;
  localparam int FUNC_W   = 4;
  localparam int POS_W    = 16;
  localparam int NCAP_W   = 16;
  localparam int STAT_W   = 3;
  localparam int LEN_W    = 9;
  localparam int CFG_W    = 9;
  localparam int GRP      = 16;
  localparam int NGRP     = (DEPTH + GRP - 1) / GRP;

  localparam logic [FUNC_W-1:0] F_INS_FIRST = 4'd0;
  localparam logic [FUNC_W-1:0] F_INS_LAST  = 4'd1;
  localparam logic [FUNC_W-1:0] F_INS_AT    = 4'd2;
  localparam logic [FUNC_W-1:0] F_EXT_FIRST = 4'd3;
  localparam logic [FUNC_W-1:0] F_EXT_LAST  = 4'd4;
  localparam logic [FUNC_W-1:0] F_EXT_AT    = 4'd5;
  localparam logic [FUNC_W-1:0] F_RD_FIRST  = 4'd6;
  localparam logic [FUNC_W-1:0] F_RD_LAST   = 4'd7;
  localparam logic [FUNC_W-1:0] F_RD_AT     = 4'd8;
  localparam logic [FUNC_W-1:0] F_CLEAR     = 4'd9;
  localparam logic [FUNC_W-1:0] F_RESIZE    = 4'd10;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;
  localparam logic [STAT_W-1:0] ST_EXCEED = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] data_handle;
    logic [BYTES_W-1:0]  byte_count;
    logic [POS_W-1:0]    position;
    logic [NCAP_W-1:0]   new_capacity;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] out_handle;
    logic [BYTES_W-1:0]  out_bytes;
    logic [LEN_W-1:0]    list_length;
    logic                list_empty;
    logic                list_full;
    logic [LEN_W-1:0]    list_capacity;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
    entry_t           ent;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_APPLY
  } state_t;

endpackage

// ----- rtl/bpl_cell.sv -----
module bpl_cell import bpl_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  entry_t           left_ent,
  input  entry_t           right_ent,
  output entry_t           ent,
  output entry_t           hit
);

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (idx > ctl.pos) begin
        ent_nxt = left_ent;
      end else if (idx == ctl.pos) begin
        ent_nxt = ctl.ent;
      end
    end else if (ctl.rem) begin
      if (idx >= ctl.pos) begin
        ent_nxt = right_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
  // only the addressed cell drives its contents into the read tree
  assign hit = (idx == ctl.pos) ? ent_r : '0;

endmodule

// ----- rtl/bpl_sel.sv -----
module bpl_sel import bpl_pkg::*; (
  input  logic   clk,
  input  entry_t hits [DEPTH],
  output entry_t pick
);

  entry_t grp_r   [NGRP];
  entry_t grp_nxt [NGRP];

  // first level: OR within each group of cells, registered
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | hits[g * GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // second level
  always_comb begin
    pick = '0;
    for (int g = 0; g < NGRP; g++) begin
      pick = pick | grp_r[g];
    end
  end

endmodule

// ----- rtl/bounded_positional_list.sv -----
// Channel  | Ports                        | Payload
// ---------+------------------------------+------------------------------
// input    | in_valid, in_ready, in_data  | in_item_t: one list operation
// result   | out_valid, out_ready,        | out_item_t: status, entry,
//          | out_data                     | length, flags, capacity
// config   | cfg_valid, cfg_ready,        | initial_capacity (9 bits)
//          | cfg_data                     |
//
// Each transaction goes through accept and decode, a registered read
// tree across the cell row, then the shift of the cell row and the
// result register load.
// One operation is in flight at a time; a waiting result stalls the apply
// step until out_ready. Reset is synchronous (rst_n low): it clears the
// length and control state and sets the capacity to DEPTH; the cell
// contents are left as they are and need no clearing.
module bounded_positional_list import bpl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              rd_ok;
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  pos;
    entry_t            ent;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  cap;
  } dec_t;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cfg_cap;
  dec_t             dec_r;
  dec_t             dec_nxt;
  out_item_t        out_r;
  out_item_t        out_nxt;
  logic             out_valid_r;
  logic             apply;
  logic             in_acc;
  logic             cfg_acc;
  cell_ctl_t        ctl;
  entry_t           pick;
  entry_t           cell_ent [DEPTH];
  entry_t           cell_hit [DEPTH];

  assign in_acc  = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------
  // Decode against the current length and capacity. These change only
  // in the apply step or on a config write while idle, so this stays
  // valid while the operation walks through the read tree.
  // ---------------------------------------------------------------
  always_comb begin
    logic [POS_W-1:0] cnt_w;
    logic             pos_ok;
    cnt_w  = POS_W'(count_r);
    pos_ok = in_data.position < cnt_w;

    dec_nxt        = '0;
    dec_nxt.ent    = '{handle: in_data.data_handle, bytes: in_data.byte_count};
    dec_nxt.count  = count_r;
    dec_nxt.cap    = cap_r;
    dec_nxt.status = ST_OK;

    case (in_data.func)
      F_INS_FIRST, F_INS_LAST, F_INS_AT: begin
        if (in_data.data_handle == '0) begin
          dec_nxt.status = ST_NULL;
        end else if (in_data.byte_count == '0) begin
          dec_nxt.status = ST_ZERO;
        end else if (count_r >= cap_r) begin
          dec_nxt.status = ST_FULL;
        end else begin
          dec_nxt.ins   = 1'b1;
          dec_nxt.count = count_r + CNT_W'(1);
          if (in_data.func == F_INS_LAST || (in_data.func == F_INS_AT && !pos_ok)) begin
            // past the end appends; count < cap <= DEPTH so it fits an index
            dec_nxt.pos = count_r[IDX_W-1:0];
          end else if (in_data.func == F_INS_AT) begin
            dec_nxt.pos = in_data.position[IDX_W-1:0];
          end
        end
      end
      F_EXT_FIRST, F_EXT_LAST, F_EXT_AT, F_RD_FIRST, F_RD_LAST, F_RD_AT: begin
        if (in_data.func == F_EXT_AT || in_data.func == F_RD_AT) begin
          dec_nxt.rd_ok = pos_ok;
          dec_nxt.pos   = in_data.position[IDX_W-1:0];
        end else begin
          dec_nxt.rd_ok = count_r != '0;
          if (in_data.func == F_EXT_LAST || in_data.func == F_RD_LAST) begin
            dec_nxt.pos = IDX_W'(count_r - CNT_W'(1));
          end
        end
        if (!dec_nxt.rd_ok) begin
          dec_nxt.status = ST_EMPTY;
        end else if (in_data.func == F_EXT_FIRST || in_data.func == F_EXT_LAST ||
                     in_data.func == F_EXT_AT) begin
          dec_nxt.rem   = 1'b1;
          dec_nxt.count = count_r - CNT_W'(1);
        end
      end
      F_CLEAR: begin
        dec_nxt.count = '0;
      end
      F_RESIZE: begin
        if (in_data.new_capacity == '0) begin
          dec_nxt.status = ST_ZERO;
        end else if (32'(in_data.new_capacity) > DEPTH) begin
          dec_nxt.status = ST_EXCEED;
        end else begin
          dec_nxt.cap = CNT_W'(in_data.new_capacity);
          if (CNT_W'(in_data.new_capacity) < count_r) begin
            dec_nxt.count = CNT_W'(in_data.new_capacity);
          end
        end
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dec_r <= dec_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_APPLY;
      S_APPLY:  if (apply) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    apply     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = 1'b1;
      end
      S_APPLY: apply = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Cell row: position p is broadcast; the row shifts right on insert
  // and left on extract in the apply cycle.
  // ---------------------------------------------------------------
  assign ctl = '{ins: apply && dec_r.ins, rem: apply && dec_r.rem,
                 pos: dec_r.pos, ent: dec_r.ent};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_left
      assign left_ent = cell_ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_right
      assign right_ent = cell_ent[i+1];
    end
    bpl_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .hit       (cell_hit[i])
    );
  end

  bpl_sel u_sel (
    .clk  (clk),
    .hits (cell_hit),
    .pick (pick)
  );

  // ---------------------------------------------------------------
  // Length, capacity and configuration
  // ---------------------------------------------------------------
  // out-of-range register values clamp into 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      cfg_cap = CNT_W'(DEPTH);
    end else begin
      cfg_cap = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cap_r   <= CNT_W'(DEPTH);
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        count_r <= '0;
        cap_r   <= cfg_cap;
      end else if (apply) begin
        count_r <= dec_r.count;
        cap_r   <= dec_r.cap;
      end
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_comb begin
    out_nxt               = '0;
    out_nxt.status        = dec_r.status;
    out_nxt.out_handle    = dec_r.rd_ok ? pick.handle : '0;
    out_nxt.out_bytes     = dec_r.rd_ok ? pick.bytes : '0;
    out_nxt.list_length   = LEN_W'(dec_r.count);
    out_nxt.list_empty    = dec_r.count == '0;
    out_nxt.list_full     = dec_r.count >= dec_r.cap;
    out_nxt.list_capacity = LEN_W'(dec_r.cap);
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_len_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("length above capacity");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r != '0 && 32'(cap_r) <= DEPTH)
    else $error("capacity out of range");

  a_accept_gathers: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_GATHER)
    else $error("accepted transaction did not enter the read tree");

  a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.list_empty == (out_data.list_length == '0)) &&
                  (out_data.list_full == (out_data.list_length >= out_data.list_capacity)))
    else $error("result flags disagree with length");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bpl_pkg::*;

  // func codes with no operation behind them
  localparam logic [FUNC_W-1:0] F_SPARE_LO = 4'd11;
  localparam logic [FUNC_W-1:0] F_SPARE_HI = 4'd15;

  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 64;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  bounded_positional_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // List shadow: entries, length and capacity as the block should hold them
  // after every accepted transaction.
  // ---------------------------------------------------------------------------
  logic [HANDLE_W-1:0] shadow_handle [DEPTH];
  logic [BYTES_W-1:0]  shadow_bytes  [DEPTH];
  int                  shadow_len = 0;
  int                  shadow_cap = DEPTH;

  out_item_t pending_results [$];   // results still owed by the block, oldest first
  int        n_fail = 0;

  int snd_idle_pct  = 0;            // chance the sender skips a cycle
  int rcv_stall_pct = 0;            // chance the receiver drops out_ready
  logic hold_req = 1'b0;            // one-shot request for a long receiver hold

  // Apply one list operation to the shadow and return the result it should give.
  function automatic out_item_t list_apply(input in_item_t op);
    out_item_t r;
    int        p;
    bit        ok;
    r = '0;
    r.status = ST_OK;
    case (op.func)
      F_INS_FIRST, F_INS_LAST, F_INS_AT: begin
        // null handle wins over zero size, zero size over full
        if (op.data_handle == '0) r.status = ST_NULL;
        else if (op.byte_count == '0) r.status = ST_ZERO;
        else if (shadow_len >= shadow_cap) r.status = ST_FULL;
        else begin
          if (op.func == F_INS_FIRST) p = 0;
          else if (op.func == F_INS_LAST) p = shadow_len;
          else p = (int'(op.position) >= shadow_len) ? shadow_len : int'(op.position);
          for (int i = shadow_len; i > p; i--) begin
            shadow_handle[i] = shadow_handle[i-1];
            shadow_bytes[i]  = shadow_bytes[i-1];
          end
          shadow_handle[p] = op.data_handle;
          shadow_bytes[p]  = op.byte_count;
          shadow_len++;
        end
      end
      F_EXT_FIRST, F_EXT_LAST, F_EXT_AT, F_RD_FIRST, F_RD_LAST, F_RD_AT: begin
        ok = (shadow_len != 0);
        if (op.func == F_EXT_LAST || op.func == F_RD_LAST) p = shadow_len - 1;
        else if (op.func == F_EXT_AT || op.func == F_RD_AT) begin
          p  = int'(op.position);
          ok = (p < shadow_len);
        end else p = 0;
        if (!ok) r.status = ST_EMPTY;
        else begin
          r.out_handle = shadow_handle[p];
          r.out_bytes  = shadow_bytes[p];
          if (op.func <= F_EXT_AT) begin
            for (int i = p; i < shadow_len - 1; i++) begin
              shadow_handle[i] = shadow_handle[i+1];
              shadow_bytes[i]  = shadow_bytes[i+1];
            end
            shadow_len--;
          end
        end
      end
      F_CLEAR: shadow_len = 0;
      F_RESIZE: begin
        if (op.new_capacity == '0) r.status = ST_ZERO;
        else if (int'(op.new_capacity) > DEPTH) r.status = ST_EXCEED;
        else begin
          // shrinking keeps the head of the list
          if (int'(op.new_capacity) < shadow_len) shadow_len = int'(op.new_capacity);
          shadow_cap = int'(op.new_capacity);
        end
      end
      default: ;  // spare codes: no effect, status ok
    endcase
    r.list_length   = LEN_W'(shadow_len);
    r.list_empty    = (shadow_len == 0);
    r.list_full     = (shadow_len >= shadow_cap);
    r.list_capacity = LEN_W'(shadow_cap);
    return r;
  endfunction

  // Random operation. ins_pct: share of inserts; misc_pct: share of the
  // rest that goes to clear, resize and the spare codes.
  function automatic in_item_t rand_op(input int ins_pct, input int misc_pct);
    in_item_t op;
    int       pick;
    op.data_handle = ($urandom_range(99) < 3) ? '0 : $urandom;
    op.byte_count  = ($urandom_range(99) < 3) ? '0 : BYTES_W'($urandom_range(1, 65535));
    // mostly positions near the current length, sometimes anywhere
    op.position    = ($urandom_range(99) < 70) ? POS_W'($urandom_range(0, shadow_len + 1))
                                               : POS_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) op.new_capacity = '0;
    else if (pick < 20) op.new_capacity = NCAP_W'($urandom_range(DEPTH + 1, 65535));
    else op.new_capacity = NCAP_W'($urandom_range(1, DEPTH));
    if ($urandom_range(99) < ins_pct) op.func = FUNC_W'($urandom_range(F_INS_FIRST, F_INS_AT));
    else if ($urandom_range(99) >= misc_pct)
      op.func = FUNC_W'($urandom_range(F_EXT_FIRST, F_RD_AT));
    else begin
      pick = $urandom_range(9);
      if (pick < 3) op.func = F_CLEAR;
      else if (pick < 8) op.func = F_RESIZE;
      else op.func = FUNC_W'($urandom_range(F_SPARE_LO, F_SPARE_HI));
    end
    return op;
  endfunction

  // Offer one transaction and hold it until accepted. Caller sits just after
  // a rising edge. The owed result is either the shadow's or a fixed one.
  task automatic send_op(input in_item_t op, input bit fixed, input out_item_t fixed_res);
    out_item_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = list_apply(op);    // shadow always advances
    pending_results.push_back(fixed ? fixed_res : r);
  endtask

  // Block counts as idle once every owed result is back plus its pipeline depth.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Capacity register write; the block empties the list and takes the
  // clamped value as its capacity.
  task automatic write_capacity(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (v == '0) shadow_cap = 1;
    else if (int'(v) > DEPTH) shadow_cap = DEPTH;
    else shadow_cap = int'(v);
    shadow_len = 0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap_cfg, input int n_ops,
                           input int ins_pct, input int misc_pct, input int hold_at);
    wait_idle();
    write_capacity(cap_cfg);
    for (int k = 0; k < n_ops; k++) begin
      if (k == hold_at) hold_req <= 1'b1;
      send_op(rand_op(ins_pct, misc_pct), 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with 'fixed' set carry their result; the rest are
  // checked against the shadow.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  op;
    bit        fixed;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic dir_row_t dir_row(input logic [FUNC_W-1:0] f,
                                       input logic [HANDLE_W-1:0] h,
                                       input logic [BYTES_W-1:0] b,
                                       input logic [POS_W-1:0] p,
                                       input logic [NCAP_W-1:0] nc,
                                       input bit fixed, input logic [STAT_W-1:0] st,
                                       input logic [HANDLE_W-1:0] oh,
                                       input logic [BYTES_W-1:0] ob,
                                       input int len, input int cap);
    dir_row_t d;
    d.op.func              = f;
    d.op.data_handle       = h;
    d.op.byte_count        = b;
    d.op.position          = p;
    d.op.new_capacity      = nc;
    d.fixed                = fixed;
    d.res.status           = st;
    d.res.out_handle       = oh;
    d.res.out_bytes        = ob;
    d.res.list_length      = LEN_W'(len);
    d.res.list_empty       = (len == 0);
    d.res.list_full        = (len >= cap);
    d.res.list_capacity    = LEN_W'(cap);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: out_ready pattern, with one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Each result transaction against the oldest owed result, field by field.
  out_item_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result: st=%0d h=%h b=%h len=%0d e=%b f=%b cap=%0d",
                   out_data.status, out_data.out_handle, out_data.out_bytes,
                   out_data.list_length, out_data.list_empty, out_data.list_full,
                   out_data.list_capacity);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.out_handle !== want.out_handle ||
            out_data.out_bytes !== want.out_bytes ||
            out_data.list_length !== want.list_length ||
            out_data.list_empty !== want.list_empty ||
            out_data.list_full !== want.list_full ||
            out_data.list_capacity !== want.list_capacity) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("mismatch at %0t: exp st=%0d h=%h b=%h len=%0d e=%b f=%b cap=%0d", $realtime,
                     want.status, want.out_handle, want.out_bytes, want.list_length,
                     want.list_empty, want.list_full, want.list_capacity);
            $display("                got st=%0d h=%h b=%h len=%0d e=%b f=%b cap=%0d",
                     out_data.status, out_data.out_handle, out_data.out_bytes,
                     out_data.list_length, out_data.list_empty, out_data.list_full,
                     out_data.list_capacity);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    // empty list after reset: a read and two extract flavors report empty
    dir_rows.push_back(dir_row(F_RD_FIRST, '0, '0, '0, '0, 1, ST_EMPTY, '0, '0, 0, 256));
    dir_rows.push_back(dir_row(F_EXT_LAST, '0, '0, '0, '0, 1, ST_EMPTY, '0, '0, 0, 256));
    dir_rows.push_back(dir_row(F_EXT_AT, '0, '0, '0, '0, 1, ST_EMPTY, '0, '0, 0, 256));
    // insert checks and their priority
    dir_rows.push_back(dir_row(F_INS_FIRST, '0, 16'h0040, '0, '0, 1, ST_NULL, '0, '0, 0, 256));
    dir_rows.push_back(dir_row(F_INS_LAST, 32'h5, '0, '0, '0, 1, ST_ZERO, '0, '0, 0, 256));
    dir_rows.push_back(dir_row(F_INS_AT, '0, '0, '0, '0, 1, ST_NULL, '0, '0, 0, 256));
    // resize rejects: zero, just above store, all ones
    dir_rows.push_back(dir_row(F_RESIZE, '0, '0, '0, '0, 1, ST_ZERO, '0, '0, 0, 256));
    dir_rows.push_back(dir_row(F_RESIZE, '0, '0, '0, 16'd257, 1, ST_EXCEED, '0, '0, 0, 256));
    dir_rows.push_back(dir_row(F_RESIZE, '0, '0, '0, 16'hFFFF, 1, ST_EXCEED, '0, '0, 0, 256));
    // capacity 2, fill it, overflow, read the tail and past the end, then back to 256
    dir_rows.push_back(dir_row(F_RESIZE, '0, '0, '0, 16'd2, 1, ST_OK, '0, '0, 0, 2));
    dir_rows.push_back(dir_row(F_INS_FIRST, 32'hFFFF_FFFF, 16'hFFFF, '0, '0,
                               1, ST_OK, '0, '0, 1, 2));
    dir_rows.push_back(dir_row(F_INS_LAST, 32'h1, 16'h1, '0, '0, 1, ST_OK, '0, '0, 2, 2));
    dir_rows.push_back(dir_row(F_INS_AT, 32'h1234, 16'h7, '0, '0, 1, ST_FULL, '0, '0, 2, 2));
    dir_rows.push_back(dir_row(F_RD_LAST, '0, '0, '0, '0, 1, ST_OK, 32'h1, 16'h1, 2, 2));
    dir_rows.push_back(dir_row(F_RD_AT, '0, '0, 16'd2, '0, 1, ST_EMPTY, '0, '0, 2, 2));
    dir_rows.push_back(dir_row(F_RESIZE, '0, '0, '0, 16'd256, 1, ST_OK, '0, '0, 2, 256));
    // position past the end appends; mid insert; reads and extracts
    dir_rows.push_back(dir_row(F_INS_AT, 32'hA5A5_0001, 16'h0100, 16'hFFFF, '0,
                               0, '0, '0, '0, 0, 0));
    dir_rows.push_back(dir_row(F_INS_AT, 32'h0000_8000, 16'h8000, 16'd1, '0,
                               0, '0, '0, '0, 0, 0));
    dir_rows.push_back(dir_row(F_RD_FIRST, '0, '0, '0, '0, 0, '0, '0, '0, 0, 0));
    dir_rows.push_back(dir_row(F_EXT_AT, '0, '0, 16'd1, '0, 0, '0, '0, '0, 0, 0));
    // spare codes do nothing
    dir_rows.push_back(dir_row(F_SPARE_LO, 32'hDEAD_BEEF, 16'h1, 16'h0, 16'h5,
                               0, '0, '0, '0, 0, 0));
    dir_rows.push_back(dir_row(F_SPARE_HI, '0, '0, 16'hFFFF, 16'hFFFF, 0, '0, '0, '0, 0, 0));
    // shrink below the length truncates the tail; then extract and clear
    dir_rows.push_back(dir_row(F_RESIZE, '0, '0, '0, 16'd1, 0, '0, '0, '0, 0, 0));
    dir_rows.push_back(dir_row(F_EXT_FIRST, '0, '0, '0, '0, 0, '0, '0, '0, 0, 0));
    dir_rows.push_back(dir_row(F_CLEAR, '0, '0, '0, '0, 0, '0, '0, '0, 0, 0));

    // reset, synchronous
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver stalls often
    snd_idle_pct  = 8;
    rcv_stall_pct = 55;
    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].res);
    in_valid <= 1'b0;

    run_phase(9'd0, 50, 45, 20, -1);          // register 0: capacity of one
    run_phase(9'h1FF, 360, 95, 0, -1);        // clamps to the store; grow to full

    // roles swapped; long receiver hold early on
    snd_idle_pct  = 55;
    rcv_stall_pct = 8;
    run_phase(9'd5, 80, 50, 15, 10);
    run_phase(CFG_W'($urandom_range(1, 511)), 60, 50, 15, -1);

    // back to back
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    run_phase(9'd16, 60, 55, 20, -1);

    wait_idle();
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #3_600_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- bounded_positional_list.f -----
rtl/bpl_pkg.sv
rtl/bpl_cell.sv
rtl/bpl_sel.sv
rtl/bounded_positional_list.sv
dv/testbench.sv
